### sv/psd_pkg.sv
`default_nettype none
package psd_pkg;
   localparam int DiffW = 33;
   localparam int FracBits = 16;
   localparam int TqW = FracBits + 1;
   localparam int ProdW = 2 * DiffW;
   localparam int Len2W = ProdW + 1;
   localparam int DistW = 33;
   localparam int RootW = 35;
   localparam int SqW = 2 * (DiffW + 1) + 1;
   localparam logic [DistW-1:0] DistMax = '1;

   typedef enum logic [1:0] {
      PART_DEGEN = 2'd0,
      PART_START = 2'd1,
      PART_END = 2'd2,
      PART_FOOT = 2'd3
   } part_type;
endpackage
`default_nettype wire

### sv/psd_sqrt.sv
`default_nettype none
// Pipelined restoring square root, one result bit per stage, rounded down and saturated.
module psd_sqrt (
   input wire logic clock,
   input wire logic reset,
   input wire logic enable,
   input wire logic in_valid,
   input wire logic [psd_pkg::SqW-1:0] in_value,
   input wire psd_pkg::part_type in_part,
   output logic out_valid,
   output logic [psd_pkg::DistW-1:0] out_root,
   output psd_pkg::part_type out_part
);
   localparam int N = psd_pkg::RootW;

   logic [N:0] valid_ff;
   logic [psd_pkg::SqW-1:0] val_ff [N+1];
   logic [N-1:0] root_ff [N+1];
   psd_pkg::part_type part_ff [N+1];

   // Stage 0 takes the input; stage k+1 decides bit N-1-k.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[N-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         val_ff[0] <= in_value;
         root_ff[0] <= '0;
         part_ff[0] <= in_part;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_bit
      logic [N-1:0] cand;
      logic [2*N-1:0] sq;
      always_comb begin
         cand = root_ff[k] | (N'(1) << (N - 1 - k));
         sq = (2*N)'(cand) * (2*N)'(cand);
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            val_ff[k+1] <= val_ff[k];
            part_ff[k+1] <= part_ff[k];
            root_ff[k+1] <= ({1'b0, val_ff[k]} >= (psd_pkg::SqW+1)'(sq)) ? cand : root_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[N];
   assign out_part = part_ff[N];
   assign out_root = (root_ff[N] > N'(psd_pkg::DistMax)) ? psd_pkg::DistMax
                                                        : root_ff[N][psd_pkg::DistW-1:0];
endmodule
`default_nettype wire

### sv/point_to_segment_distance.sv
`default_nettype none
// Point to segment distance, streaming.
// The req_ channel carries a point and a segment (six signed Q16.16 words); the rsp_
// channel returns the floor-rounded Euclidean distance (unsigned Q17.16) and the
// nearest part of the segment (tuser).
// One item can enter every cycle while the receiver does not stall. The stages are: 4 stages of
// differences, products and classification, 17 stages of the restoring divider for t,
// 3 stages for the foot offset and squares, 36 stages of the bit-serial square root,
// and the output register.
// The whole pipeline advances together; when the receiver stalls with a result
// waiting at the output register, every stage holds and req_tready drops, so
// nothing is lost or repeated. Reset clears all valid bits; payload is not cleared.
module point_to_segment_distance (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   // point_x, point_y, start_x, start_y, end_x, end_y (from bit 0)
   input wire logic [191:0] req_tdata,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // dist_res, zero fill to 40 bits
   output logic [39:0] rsp_tdata,
   // nearest_part
   output logic [1:0] rsp_tuser
);
   localparam int DW = psd_pkg::DiffW;
   localparam int PW = psd_pkg::ProdW;
   localparam int LW = psd_pkg::Len2W;
   localparam int TW = psd_pkg::TqW;
   localparam int FB = psd_pkg::FracBits;
   localparam int EW = DW + 1;

   logic enable;
   assign enable = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   logic signed [31:0] px, py, sx, sy, qx, qy;
   assign {qy, qx, sy, sx, py, px} = req_tdata;

   // Stage 1: differences.
   logic v1_ff;
   logic signed [DW-1:0] ux1_ff, uy1_ff, dx1_ff, dy1_ff, wx1_ff, wy1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (enable) v1_ff <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         ux1_ff <= DW'(px) - DW'(sx);
         uy1_ff <= DW'(py) - DW'(sy);
         dx1_ff <= DW'(qx) - DW'(sx);
         dy1_ff <= DW'(qy) - DW'(sy);
         wx1_ff <= DW'(px) - DW'(qx);
         wy1_ff <= DW'(py) - DW'(qy);
      end
   end

   // Stage 2: the four products.
   logic v2_ff;
   logic signed [PW-1:0] pxd2_ff, pyd2_ff, dxx2_ff, dyy2_ff;
   logic signed [DW-1:0] ux2_ff, uy2_ff, dx2_ff, dy2_ff, wx2_ff, wy2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (enable) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         pxd2_ff <= PW'(ux1_ff) * PW'(dx1_ff);
         pyd2_ff <= PW'(uy1_ff) * PW'(dy1_ff);
         dxx2_ff <= PW'(dx1_ff) * PW'(dx1_ff);
         dyy2_ff <= PW'(dy1_ff) * PW'(dy1_ff);
         {ux2_ff, uy2_ff, dx2_ff, dy2_ff, wx2_ff, wy2_ff} <=
            {ux1_ff, uy1_ff, dx1_ff, dy1_ff, wx1_ff, wy1_ff};
      end
   end

   // Stage 3: dot product and squared length.
   logic v3_ff;
   logic signed [LW-1:0] dot3_ff;
   logic [LW-1:0] len3_ff;
   logic signed [DW-1:0] ux3_ff, uy3_ff, dx3_ff, dy3_ff, wx3_ff, wy3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (enable) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         dot3_ff <= LW'(pxd2_ff) + LW'(pyd2_ff);
         len3_ff <= LW'($unsigned(dxx2_ff)) + LW'($unsigned(dyy2_ff));
         {ux3_ff, uy3_ff, dx3_ff, dy3_ff, wx3_ff, wy3_ff} <=
            {ux2_ff, uy2_ff, dx2_ff, dy2_ff, wx2_ff, wy2_ff};
      end
   end

   // Stage 4: classify and pick endpoint offsets.
   psd_pkg::part_type part_in;
   always_comb begin
      if (dx3_ff == '0 && dy3_ff == '0) part_in = psd_pkg::PART_DEGEN;
      else if (dot3_ff[LW-1]) part_in = psd_pkg::PART_START;
      else if ($unsigned(dot3_ff) > len3_ff) part_in = psd_pkg::PART_END;
      else part_in = psd_pkg::PART_FOOT;
   end
   logic v4_ff;
   psd_pkg::part_type part4_ff;
   logic [LW-1:0] rem4_ff, len4_ff;
   logic signed [DW-1:0] ex4_ff, ey4_ff, dx4_ff, dy4_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (enable) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         part4_ff <= part_in;
         rem4_ff <= (part_in == psd_pkg::PART_FOOT) ? $unsigned(dot3_ff) : '0;
         len4_ff <= len3_ff;
         ex4_ff <= (part_in == psd_pkg::PART_END) ? wx3_ff : ux3_ff;
         ey4_ff <= (part_in == psd_pkg::PART_END) ? wy3_ff : uy3_ff;
         dx4_ff <= dx3_ff;
         dy4_ff <= dy3_ff;
      end
   end

   // Divider: TW stages, one quotient bit each. dot <= len, so a doubled
   // remainder fits in LW+1 bits.
   logic dv_ff [TW];
   logic [LW-1:0] r_ff [TW];
   logic [LW-1:0] l_ff [TW];
   logic [TW-1:0] q_ff [TW];
   psd_pkg::part_type dp_ff [TW];
   logic signed [DW-1:0] dex_ff [TW], dey_ff [TW], ddx_ff [TW], ddy_ff [TW];
   for (genvar k = 0; k < TW; k++) begin : g_div
      logic v_prev;
      logic [LW-1:0] r_prev, l_prev;
      logic [TW-1:0] q_prev;
      psd_pkg::part_type p_prev;
      logic signed [DW-1:0] ex_prev, ey_prev, dx_prev, dy_prev;
      logic [LW:0] rr, diff;
      // The first stage takes the classify stage, the others the stage before.
      if (k == 0) begin : g_first
         assign v_prev = v4_ff;
         assign r_prev = rem4_ff;
         assign l_prev = len4_ff;
         assign q_prev = '0;
         assign p_prev = part4_ff;
         assign ex_prev = ex4_ff;
         assign ey_prev = ey4_ff;
         assign dx_prev = dx4_ff;
         assign dy_prev = dy4_ff;
      end else begin : g_next
         assign v_prev = dv_ff[k-1];
         assign r_prev = r_ff[k-1];
         assign l_prev = l_ff[k-1];
         assign q_prev = q_ff[k-1];
         assign p_prev = dp_ff[k-1];
         assign ex_prev = dex_ff[k-1];
         assign ey_prev = dey_ff[k-1];
         assign dx_prev = ddx_ff[k-1];
         assign dy_prev = ddy_ff[k-1];
      end
      always_comb begin
         rr = (k == 0) ? {1'b0, r_prev} : {r_prev, 1'b0};
         diff = rr - {1'b0, l_prev};
      end
      always_ff @(posedge clock) begin
         if (reset) dv_ff[k] <= 1'b0;
         else if (enable) dv_ff[k] <= v_prev;
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            r_ff[k] <= diff[LW] ? rr[LW-1:0] : diff[LW-1:0];
            q_ff[k] <= {q_prev[TW-2:0], !diff[LW]};
            l_ff[k] <= l_prev;
            dp_ff[k] <= p_prev;
            dex_ff[k] <= ex_prev;
            dey_ff[k] <= ey_prev;
            ddx_ff[k] <= dx_prev;
            ddy_ff[k] <= dy_prev;
         end
      end
   end

   // Foot stage A: tq * D (floor shift is an arithmetic shift).
   localparam int MW = DW + TW + 1;
   logic va_ff;
   psd_pkg::part_type pa_ff;
   logic signed [MW-1:0] mx_ff, my_ff;
   logic signed [DW-1:0] ax_ff, ay_ff;
   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else if (enable) va_ff <= dv_ff[TW-1];
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         pa_ff <= dp_ff[TW-1];
         mx_ff <= MW'(signed'({1'b0, q_ff[TW-1]})) * MW'(ddx_ff[TW-1]);
         my_ff <= MW'(signed'({1'b0, q_ff[TW-1]})) * MW'(ddy_ff[TW-1]);
         ax_ff <= dex_ff[TW-1];
         ay_ff <= dey_ff[TW-1];
      end
   end

   // Foot stage B: offsets.
   logic vb_ff;
   psd_pkg::part_type pb_ff;
   logic signed [EW-1:0] bx_ff, by_ff;
   logic signed [MW-1:0] shx, shy;
   assign shx = mx_ff >>> FB;
   assign shy = my_ff >>> FB;
   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else if (enable) vb_ff <= va_ff;
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         pb_ff <= pa_ff;
         bx_ff <= EW'(ax_ff) - ((pa_ff == psd_pkg::PART_FOOT) ? EW'(shx) : EW'(0));
         by_ff <= EW'(ay_ff) - ((pa_ff == psd_pkg::PART_FOOT) ? EW'(shy) : EW'(0));
      end
   end

   // Foot stage C: squares and sum.
   logic vc_ff;
   psd_pkg::part_type pc_ff;
   logic [psd_pkg::SqW-1:0] sq_ff;
   logic [EW-1:0] mgx, mgy;
   assign mgx = bx_ff[EW-1] ? EW'(-bx_ff) : EW'(bx_ff);
   assign mgy = by_ff[EW-1] ? EW'(-by_ff) : EW'(by_ff);
   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else if (enable) vc_ff <= vb_ff;
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         pc_ff <= pb_ff;
         sq_ff <= psd_pkg::SqW'(mgx) * psd_pkg::SqW'(mgx)
                + psd_pkg::SqW'(mgy) * psd_pkg::SqW'(mgy);
      end
   end

   logic sv_valid;
   logic [psd_pkg::DistW-1:0] root;
   psd_pkg::part_type spart;
   psd_sqrt u_sqrt (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(vc_ff), .in_value(sq_ff), .in_part(pc_ff),
      .out_valid(sv_valid), .out_root(root), .out_part(spart)
   );

   // Output register.
   logic out_v_ff;
   logic [psd_pkg::DistW-1:0] dist_ff;
   psd_pkg::part_type opart_ff;
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (enable) out_v_ff <= sv_valid;
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         dist_ff <= root;
         opart_ff <= spart;
      end
   end
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {7'd0, dist_ff};
   assign rsp_tuser = opart_ff;
endmodule
`default_nettype wire

### sv/psd_checker.sv
`default_nettype none
// Port-level checks for the distance block.
module psd_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic [1:0] rsp_tuser
);
   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");
   // Input is refused exactly while a result is stalled.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready mismatch");
   // Padding bits stay zero.
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:33] == 7'd0)
      else $error("padding set");
   // Nothing comes out right after reset.
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("valid after reset");
endmodule

bind point_to_segment_distance psd_checker u_psd_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);
`default_nettype wire

### tb/psd_checker.sv
`timescale 1ns / 1ps
module psd_scoreboard (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic [191:0] req_tdata,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic [1:0] rsp_tuser,
   output int fail_count,
   output int pending_count
);
   typedef struct packed {
      logic [psd_pkg::DistW-1:0] dist_res;
      psd_pkg::part_type part;
   } seg_answer_type;

   seg_answer_type answer_queue[$];

   // Integer square root rounded down, saturated to the distance width.
   function automatic logic [psd_pkg::DistW-1:0] floor_root(logic [127:0] v);
      logic [psd_pkg::RootW-1:0] r;
      logic [psd_pkg::RootW-1:0] c;
      r = '0;
      for (int b = psd_pkg::RootW - 1; b >= 0; b--) begin
         c = r | (psd_pkg::RootW'(1) << b);
         if (128'(c) * 128'(c) <= v) r = c;
      end
      if (r > psd_pkg::RootW'(psd_pkg::DistMax)) return psd_pkg::DistMax;
      return r[psd_pkg::DistW-1:0];
   endfunction

   function automatic logic [psd_pkg::DistW-1:0] offset_length(logic signed [63:0] ex,
                                                                logic signed [63:0] ey);
      logic [127:0] sum;
      logic [63:0] mx, my;
      mx = ex < 0 ? -ex : ex;
      my = ey < 0 ? -ey : ey;
      sum = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
      return floor_root(sum);
   endfunction

   // Expected distance and nearest part for one query.
   function automatic seg_answer_type segment_distance(logic [191:0] d);
      logic signed [63:0] px, py, sx, sy, qx, qy, dx, dy, ux, uy, fx, fy;
      logic signed [127:0] dot, len2;
      logic [127:0] tq;
      seg_answer_type a;
      px = 64'(signed'(d[31:0]));
      py = 64'(signed'(d[63:32]));
      sx = 64'(signed'(d[95:64]));
      sy = 64'(signed'(d[127:96]));
      qx = 64'(signed'(d[159:128]));
      qy = 64'(signed'(d[191:160]));
      dx = qx - sx;
      dy = qy - sy;
      ux = px - sx;
      uy = py - sy;
      if (dx == 0 && dy == 0) begin
         a.dist_res = offset_length(ux, uy);
         a.part = psd_pkg::PART_DEGEN;
      end else begin
         dot = 128'(ux) * 128'(dx) + 128'(uy) * 128'(dy);
         len2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
         if (dot < 0) begin
            a.dist_res = offset_length(ux, uy);
            a.part = psd_pkg::PART_START;
         end else if (dot > len2) begin
            a.dist_res = offset_length(px - qx, py - qy);
            a.part = psd_pkg::PART_END;
         end else begin
            // t truncated, foot offset floored toward minus infinity.
            tq = (dot <<< psd_pkg::FracBits) / len2;
            fx = 64'((128'(signed'(tq)) * 128'(dx)) >>> psd_pkg::FracBits);
            fy = 64'((128'(signed'(tq)) * 128'(dy)) >>> psd_pkg::FracBits);
            a.dist_res = offset_length(ux - fx, uy - fy);
            a.part = psd_pkg::PART_FOOT;
         end
      end
      return a;
   endfunction

   assign pending_count = answer_queue.size();

   // Predict on each input transfer, compare on each result transfer.
   always @(posedge clock) begin
      seg_answer_type want;
      if (reset) begin
         answer_queue.delete();
         fail_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (answer_queue.size() == 0) begin
               $display("%0t: unexpected result dist=%h part=%0d", $time,
                        rsp_tdata, rsp_tuser);
               fail_count <= fail_count + 1;
            end else begin
               want = answer_queue.pop_front();
               if (rsp_tdata != 40'(want.dist_res) || rsp_tuser != want.part) begin
                  $display("%0t: expected dist=%h part=%0d, actual dist=%h part=%0d",
                           $time, want.dist_res, want.part, rsp_tdata, rsp_tuser);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) answer_queue.push_back(segment_distance(req_tdata));
      end
   end
endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [191:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   int fail_count;
   int pending_count;
   int cycle_count = 0;
   bit stall_enable = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   point_to_segment_distance DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   psd_scoreboard checker_inst (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .fail_count(fail_count), .pending_count(pending_count)
   );

   // Receiver stalls at random; some stretches never stall.
   always @(posedge clock) begin
      int mode;
      mode = $urandom_range(0, 99);
      if (!stall_enable) rsp_tready <= 1'b1;
      else rsp_tready <= (mode < 70);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($signed($urandom_range(0, 2000)) - 1000);
         3: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000);
         default: return $urandom;
      endcase
   endfunction

   // Present one query and wait for its transfer.
   task automatic send_query(logic [31:0] px, py, sx, sy, ex, ey);
      req_tdata <= {ey, ex, sy, sx, py, px};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic pause_sender(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      logic [31:0] p[6];
      logic [31:0] mn, mx;
      int burst;
      mn = 32'h8000_0000;
      mx = 32'h7fff_ffff;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: degenerate segment, both endpoints, interior, t exactly 0 and 1.
      send_query(0, 0, 0, 0, 0, 0);
      send_query(mx, mx, mn, mn, mn, mn);
      send_query(mn, mn, mx, mx, mx, mx);
      send_query(32'h0001_0000, 0, 0, 0, 0, 0);
      send_query(-32'sh0001_0000, 0, 0, 0, 32'h0001_0000, 0);
      send_query(32'h0003_0000, 0, 0, 0, 32'h0001_0000, 0);
      send_query(32'h0000_8000, 32'h0001_0000, 0, 0, 32'h0001_0000, 0);
      send_query(0, 32'h0005_0000, 0, 0, 32'h0001_0000, 0);
      send_query(32'h0001_0000, 32'h0005_0000, 0, 0, 32'h0001_0000, 0);
      send_query(mx, mn, mn, mx, mx, mn);
      send_query(mn, mx, mn, mn, mx, mx);
      send_query(mx, mx, mn, mn, mx, mx);
      send_query(mn, mn, mx, mn, mn, mx);
      send_query(0, 0, mn, mx, mx, mn);
      send_query(mx, 0, mn, mn, mx, mx);
      send_query(7, 3, 1, 2, 4, 9);
      send_query(-32'sd5, 3, 1, -32'sd2, 4, 9);
      send_query(mx, mx, mx, mx, mn, mx);
      send_query(32'hffff_ffff, 32'hffff_ffff, 0, 0, 32'h5555_5555, 32'haaaa_aaaa);

      // Sender holds off until everything is back.
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);

      // Random queries in bursts with gaps.
      for (int i = 0; i < 1600; ) begin
         burst = $urandom_range(1, 40);
         if (i > 800 && i < 1000) stall_enable = 1'b0;
         else stall_enable = 1'b1;
         for (int k = 0; k < burst && i < 1600; k++, i++) begin
            foreach (p[j]) p[j] = pick_coord();
            if ($urandom_range(0, 9) == 0) begin
               p[4] = p[2];
               p[5] = p[3];
            end
            send_query(p[0], p[1], p[2], p[3], p[4], p[5]);
         end
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
      end
      req_tvalid <= 1'b0;
      stall_enable = 1'b1;

      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
